// ===== hdl/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared widths, register indexes, reset values and types of the Sobel
// gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

   // Pixel and result widths.
   localparam int PIX_W  = 8;
   localparam int ROOT_W = 8;

   // Configuration registers.
   localparam int FW_W        = 12;
   localparam int FH_W        = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Geometry limits.
   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int MIN_SIZE          = 3;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int ROW_W             = 12;

   // Arithmetic widths: a gradient is at most 4 * 255 in magnitude, the sum of
   // squares stays below 2^21, and the root is exact below 2^16.
   localparam int GRAD_W      = 11;
   localparam int COLSUM_W    = 10;
   localparam int SQ_W        = 21;
   localparam int ROOT_IN_W   = 16;
   localparam int REM_W       = 10;
   localparam int SQRT_STAGES = 8;

   localparam logic [ROOT_W-1:0] MAG_MAX = 8'd255;

   typedef struct packed {
      logic row_end;
      logic frame_end;
   } flag_type;

endpackage

// ===== hdl/sgm_ram.sv =====
// ----------------------------------------------------------------------------
// sgm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds its value while no read is issued.
// ----------------------------------------------------------------------------
module sgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sobel_gradient_magnitude.sv =====
// A result shows on rsp_valid after its window's last pixel has passed stage 1,
// the gradient stage, the square root pipeline and the output register.
// Throughput: one pixel per cycle while no result waits; both line stores are
// read for the new column as the previous one is written back via a separate port.
// Reset clears the counters, the window, the pipeline and the configuration
// (640 x 480); the line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// Streaming 3x3 Sobel filter: two line stores in RAM, a 3x3 window, squared
// gradients and an 8-stage pipelined integer square root, saturated to 255.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude
   import sgm_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIX_W-1:0]       req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ROOT_W-1:0]      rsp_magnitude,
   output logic                   rsp_row_end,
   output logic                   rsp_frame_end,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;

   // Configuration.
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;

   // Position counters.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Stage 1: pixel waiting for its line store read data.
   logic             s1_valid_ff;
   logic             s1_emit_ff, s1_emit_in;
   flag_type         s1_flag_ff, s1_flag_in;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0] s1_idx_ff;

   // Window: [0..2] column c-2, [3..5] column c-1; top, middle, bottom.
   logic [PIX_W-1:0] win_ff [6];

   // Stage 2: gradients.
   logic                     s2_valid_ff, s2_valid_in;
   flag_type                 s2_flag_ff;
   logic signed [GRAD_W-1:0] s2_gx_ff, s2_gx_in;
   logic signed [GRAD_W-1:0] s2_gy_ff, s2_gy_in;

   // Square root pipeline; entry 0 holds the sum of squares.
   logic                 rt_valid_ff [SQRT_STAGES+1];
   flag_type             rt_flag_ff  [SQRT_STAGES+1];
   logic                 rt_sat_ff   [SQRT_STAGES+1];
   logic [ROOT_IN_W-1:0] rt_val_ff   [SQRT_STAGES+1];
   logic [REM_W-1:0]     rt_rem_ff   [SQRT_STAGES+1];
   logic [REM_W-1:0]     rt_rem_in   [SQRT_STAGES+1];
   logic [ROOT_W-1:0]    rt_root_ff  [SQRT_STAGES+1];
   logic [ROOT_W-1:0]    rt_root_in  [SQRT_STAGES+1];

   // Output register.
   logic              rsp_valid_ff;
   logic [ROOT_W-1:0] rsp_magnitude_ff, rsp_magnitude_in;
   flag_type          rsp_flag_ff;

   logic advance;
   logic accept;

   logic [WID_W-1:0] eff_width;
   logic [WID_W-1:0] fw_ext;
   logic [WID_W-1:0] col_ext;
   logic [WID_W-1:0] col_inc;
   logic [FH_W-1:0]  eff_height;
   logic [FH_W-1:0]  row_ext;
   logic [FH_W-1:0]  row_inc;

   logic [PIX_W-1:0]    upper_rd, middle_rd;
   logic [COLSUM_W-1:0] sum_right, sum_left, sum_top, sum_bottom;

   logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
   logic [SQ_W-1:0]            sq_sum;

   logic [REM_W+1:0] rem_shift [SQRT_STAGES];
   logic [REM_W+1:0] trial     [SQRT_STAGES];

   // The whole pipeline moves together; it halts only while a result waits.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   // ------------------------------------------------------------------------
   // Geometry and counters
   // ------------------------------------------------------------------------
   always_comb begin
      fw_ext = WID_W'(frame_width_ff);
      if (fw_ext < WID_W'(MIN_SIZE)) begin
         eff_width = WID_W'(MIN_SIZE);
      end else if (fw_ext > WID_W'(MAX_WIDTH)) begin
         eff_width = WID_W'(MAX_WIDTH);
      end else begin
         eff_width = fw_ext;
      end

      if (frame_height_ff < FH_W'(MIN_SIZE)) begin
         eff_height = FH_W'(MIN_SIZE);
      end else if (frame_height_ff > FH_W'(HEIGHT_LIMIT)) begin
         eff_height = FH_W'(HEIGHT_LIMIT);
      end else begin
         eff_height = frame_height_ff;
      end

      col_ext = WID_W'(col_ff);
      row_ext = FH_W'(row_ff);
      col_inc = col_ext + WID_W'(1);

      if (col_inc >= eff_width) begin
         col_in  = '0;
         row_inc = row_ext + FH_W'(1);
      end else begin
         col_in  = col_inc[COL_W-1:0];
         row_inc = row_ext;
      end
      // A row beyond a height that shrank also wraps.
      if (row_inc >= eff_height) begin
         row_in = '0;
      end else begin
         row_in = row_inc[ROW_W-1:0];
      end

      s1_emit_in = (col_ext >= WID_W'(2)) && (row_ext >= FH_W'(2)) &&
                   (col_ext < eff_width) && (row_ext < eff_height);
      s1_flag_in.row_end   = (col_ext == eff_width - WID_W'(1));
      s1_flag_in.frame_end = s1_flag_in.row_end && (row_ext == eff_height - FH_W'(1));
   end

   // ------------------------------------------------------------------------
   // Line stores: read the current column at transfer, write it back from
   // stage 1 with the rows shifted up.
   // ------------------------------------------------------------------------
   sgm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (advance && s1_valid_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (middle_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (upper_rd)
   );

   sgm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle_ram (
      .clock   (clock),
      .wr_en   (advance && s1_valid_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (middle_rd)
   );

   // ------------------------------------------------------------------------
   // Gradients, squares and the square root steps
   // ------------------------------------------------------------------------
   always_comb begin
      sum_right  = COLSUM_W'(upper_rd) + {1'b0, middle_rd, 1'b0} + COLSUM_W'(s1_pixel_ff);
      sum_left   = COLSUM_W'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + COLSUM_W'(win_ff[2]);
      sum_top    = COLSUM_W'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + COLSUM_W'(upper_rd);
      sum_bottom = COLSUM_W'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + COLSUM_W'(s1_pixel_ff);
      s2_gx_in   = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
      s2_gy_in   = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bottom});
      s2_valid_in = s1_valid_ff && s1_emit_ff;

      gx_sq  = s2_gx_ff * s2_gx_ff;
      gy_sq  = s2_gy_ff * s2_gy_ff;
      sq_sum = SQ_W'(gx_sq) + SQ_W'(gy_sq);

      rt_rem_in[0]  = '0;
      rt_root_in[0] = '0;
      // Restoring square root, one pair of bits per stage, top pair first.
      for (int i = 0; i < SQRT_STAGES; i++) begin
         rem_shift[i] = {rt_rem_ff[i], rt_val_ff[i][2*(SQRT_STAGES-1-i) +: 2]};
         trial[i]     = {2'b00, rt_root_ff[i], 2'b01};
         if (rem_shift[i] >= trial[i]) begin
            rt_rem_in[i+1]  = REM_W'(rem_shift[i] - trial[i]);
            rt_root_in[i+1] = {rt_root_ff[i][ROOT_W-2:0], 1'b1};
         end else begin
            rt_rem_in[i+1]  = REM_W'(rem_shift[i]);
            rt_root_in[i+1] = {rt_root_ff[i][ROOT_W-2:0], 1'b0};
         end
      end

      rsp_magnitude_in = rt_sat_ff[SQRT_STAGES] ? MAG_MAX : rt_root_ff[SQRT_STAGES];
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
         for (int i = 0; i <= SQRT_STAGES; i++) begin
            rt_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data[FW_W-1:0];
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data[FH_W-1:0];
               default: ;
            endcase
         end

         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end

         if (advance) begin
            s1_valid_ff <= accept;
            s1_emit_ff  <= s1_emit_in;
            s1_flag_ff  <= s1_flag_in;
            s1_pixel_ff <= req_pixel;
            s1_idx_ff   <= col_ff;

            if (s1_valid_ff) begin
               win_ff[0] <= win_ff[3];
               win_ff[1] <= win_ff[4];
               win_ff[2] <= win_ff[5];
               win_ff[3] <= upper_rd;
               win_ff[4] <= middle_rd;
               win_ff[5] <= s1_pixel_ff;
            end

            s2_valid_ff <= s2_valid_in;
            s2_flag_ff  <= s1_flag_ff;
            s2_gx_ff    <= s2_gx_in;
            s2_gy_ff    <= s2_gy_in;

            rt_valid_ff[0] <= s2_valid_ff;
            rt_flag_ff[0]  <= s2_flag_ff;
            rt_sat_ff[0]   <= |sq_sum[SQ_W-1:ROOT_IN_W];
            rt_val_ff[0]   <= sq_sum[ROOT_IN_W-1:0];
            rt_rem_ff[0]   <= rt_rem_in[0];
            rt_root_ff[0]  <= rt_root_in[0];
            for (int i = 1; i <= SQRT_STAGES; i++) begin
               rt_valid_ff[i] <= rt_valid_ff[i-1];
               rt_flag_ff[i]  <= rt_flag_ff[i-1];
               rt_sat_ff[i]   <= rt_sat_ff[i-1];
               rt_val_ff[i]   <= rt_val_ff[i-1];
               rt_rem_ff[i]   <= rt_rem_in[i];
               rt_root_ff[i]  <= rt_root_in[i];
            end

            rsp_valid_ff     <= rt_valid_ff[SQRT_STAGES];
            rsp_magnitude_ff <= rsp_magnitude_in;
            rsp_flag_ff      <= rt_flag_ff[SQRT_STAGES];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_magnitude_ff;
   assign rsp_row_end   = rsp_flag_ff.row_end;
   assign rsp_frame_end = rsp_flag_ff.frame_end;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // A new read never hits the column being written back in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      accept && s1_valid_ff |-> col_ff != s1_idx_ff)
      else $error("line store read and write-back address the same column");

   // A gradient enters stage 2 only from a valid pixel in stage 1.
   a_s2_source: assert property (@(posedge clock) disable iff (reset)
      $rose(s2_valid_ff) |-> $past(s1_valid_ff) && $past(s1_emit_ff))
      else $error("gradient stage loaded without a completed window");

   // The root leaving the pipeline is exact for unsaturated values.
   a_root_exact: assert property (@(posedge clock) disable iff (reset)
      rt_valid_ff[SQRT_STAGES] && !rt_sat_ff[SQRT_STAGES] |->
         (18'(rt_root_ff[SQRT_STAGES]) * 18'(rt_root_ff[SQRT_STAGES])
             <= 18'(rt_val_ff[SQRT_STAGES])) &&
         ((18'(rt_root_ff[SQRT_STAGES]) + 18'd1) * (18'(rt_root_ff[SQRT_STAGES]) + 18'd1)
             > 18'(rt_val_ff[SQRT_STAGES])))
      else $error("square root stage result is not the floor root");

   // The last pixel of a frame is also the last of its row.
   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end flagged without row end");

endmodule
